@@ src/roman_numeral_encoder_assert.svh @@
// assertion macros for the roman numeral encoder
// each expects clk and rst_n in scope
`ifndef ROMAN_NUMERAL_ENCODER_ASSERT_SVH
`define ROMAN_NUMERAL_ENCODER_ASSERT_SVH

`ifndef SYNTH
`define RNE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("roman numeral encoder: assertion failed");
`define RNE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("roman numeral encoder: assertion failed");
`else
`define RNE_ASSERT_IMP(lbl, ante, cons)
`define RNE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ src/rne_pkg.sv @@
package rne_pkg;

    localparam int unsigned VALUE_W  = 12;
    localparam int unsigned SYMBOL_W = 7;
    localparam int unsigned STEP_W   = 4;

    localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;
    localparam logic [STEP_W-1:0]  LAST_STEP = 4'd12;

    localparam logic [SYMBOL_W-1:0] CH_NONE = 7'h00;
    localparam logic [SYMBOL_W-1:0] CH_I    = 7'h49;
    localparam logic [SYMBOL_W-1:0] CH_V    = 7'h56;
    localparam logic [SYMBOL_W-1:0] CH_X    = 7'h58;
    localparam logic [SYMBOL_W-1:0] CH_L    = 7'h4C;
    localparam logic [SYMBOL_W-1:0] CH_C    = 7'h43;
    localparam logic [SYMBOL_W-1:0] CH_D    = 7'h44;
    localparam logic [SYMBOL_W-1:0] CH_M    = 7'h4D;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RUN,
        ST_PAIR
    } state_t;

    // one microcode word: weight, letters, and jump target when the weight does not fit
    typedef struct packed {
        logic [VALUE_W-1:0]  weight;
        logic [SYMBOL_W-1:0] first;
        logic [SYMBOL_W-1:0] second;
        logic [STEP_W-1:0]   skip_to;
    } ucode_t;

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        case (step)
            4'd0:    w = '{12'd1000, CH_M, CH_NONE, 4'd1};
            4'd1:    w = '{12'd900,  CH_C, CH_M,    4'd2};
            4'd2:    w = '{12'd500,  CH_D, CH_NONE, 4'd3};
            4'd3:    w = '{12'd400,  CH_C, CH_D,    4'd4};
            4'd4:    w = '{12'd100,  CH_C, CH_NONE, 4'd5};
            4'd5:    w = '{12'd90,   CH_X, CH_C,    4'd6};
            4'd6:    w = '{12'd50,   CH_L, CH_NONE, 4'd7};
            4'd7:    w = '{12'd40,   CH_X, CH_L,    4'd8};
            4'd8:    w = '{12'd10,   CH_X, CH_NONE, 4'd9};
            4'd9:    w = '{12'd9,    CH_I, CH_X,    4'd10};
            4'd10:   w = '{12'd5,    CH_V, CH_NONE, 4'd11};
            4'd11:   w = '{12'd4,    CH_I, CH_V,    4'd12};
            4'd12:   w = '{12'd1,    CH_I, CH_NONE, 4'd12};
            default: w = '{12'd1,    CH_I, CH_NONE, 4'd12};
        endcase
        return w;
    endfunction

endpackage

@@ src/roman_numeral_encoder.sv @@
// Converts one unsigned number per input transfer into its Roman numeral, sent
// as a run of ASCII letters (I V X L C D M), one letter per output transfer, with
// tlast on the final letter; only the standard subtractive pairs (CM CD XC XL IX IV)
// are used. Zero and numbers above 3999 give a single transfer with symbol zero,
// tlast and the error flag in tuser. A 13-word microcode table (M, CM, D, ... I)
// drives a subtract-and-compare datapath: each cycle in the loop either sends a
// letter and subtracts the weight, or jumps to the next table word; a pair's second
// letter is sent in a separate step with no subtraction, and a letter waits while
// the output is held back. After acceptance the number is range-checked, then its
// letters are sent. The next number is taken only once the last letter has been
// loaded into the output register.
module roman_numeral_encoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] value, [15:12] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] symbol, [7] zero
    output logic        m_tlast,
    output logic [0:0]  m_tuser    // [0] range_error
);

`include "roman_numeral_encoder_assert.svh"

    // sequencer state
    rne_pkg::state_t                    state_reg, state_next;
    logic [rne_pkg::STEP_W-1:0]         pc_reg, pc_next;
    logic [rne_pkg::VALUE_W-1:0]        remaining_reg, remaining_next;
    logic [rne_pkg::SYMBOL_W-1:0]       pending_reg, pending_next;

    // output register
    logic                               out_valid_reg, out_valid_next;
    logic [rne_pkg::SYMBOL_W-1:0]       symbol_reg, symbol_next;
    logic                               last_reg, last_next;
    logic                               error_reg, error_next;

    rne_pkg::ucode_t                    word;
    logic [rne_pkg::VALUE_W-1:0]        diff;
    logic                               fits;
    logic                               slot_free;
    logic                               in_xfer;
    logic                               out_of_range;

    assign word         = rne_pkg::ucode_rom(pc_reg);
    assign diff         = remaining_reg - word.weight;
    assign fits         = remaining_reg >= word.weight;
    assign slot_free    = !out_valid_reg || m_tready;
    assign in_xfer      = s_tvalid && s_tready;
    assign out_of_range = (remaining_reg == '0) || (remaining_reg > rne_pkg::MAX_VALUE);

    assign s_tready = (state_reg == rne_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, symbol_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = error_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rne_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = rne_pkg::ST_CHECK;
                end
            end
            rne_pkg::ST_CHECK:
            begin
                if (out_of_range)
                begin
                    if (slot_free)
                    begin
                        state_next = rne_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    state_next = rne_pkg::ST_RUN;
                end
            end
            rne_pkg::ST_RUN:
            begin
                if (fits && slot_free)
                begin
                    if (word.second != rne_pkg::CH_NONE)
                    begin
                        state_next = rne_pkg::ST_PAIR;
                    end
                    else if (diff == '0)
                    begin
                        state_next = rne_pkg::ST_IDLE;
                    end
                end
            end
            rne_pkg::ST_PAIR:
            begin
                if (slot_free)
                begin
                    state_next = (remaining_reg == '0) ? rne_pkg::ST_IDLE : rne_pkg::ST_RUN;
                end
            end
            default:
            begin
                state_next = rne_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and output register control
    always_comb
    begin
        pc_next        = pc_reg;
        remaining_next = remaining_reg;
        pending_next   = pending_reg;
        out_valid_next = out_valid_reg && !m_tready;
        symbol_next    = symbol_reg;
        last_next      = last_reg;
        error_next     = error_reg;
        case (state_reg)
            rne_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    remaining_next = s_tdata[rne_pkg::VALUE_W-1:0];
                    pc_next        = '0;
                    pending_next   = rne_pkg::CH_NONE;
                end
            end
            rne_pkg::ST_CHECK:
            begin
                // out-of-range number: one error transfer
                if (out_of_range && slot_free)
                begin
                    out_valid_next = 1'b1;
                    symbol_next    = rne_pkg::CH_NONE;
                    last_next      = 1'b1;
                    error_next     = 1'b1;
                    remaining_next = '0;
                end
            end
            rne_pkg::ST_RUN:
            begin
                if (!fits)
                begin
                    // conditional jump to the next weight
                    pc_next = word.skip_to;
                end
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    symbol_next    = word.first;
                    last_next      = (word.second == rne_pkg::CH_NONE) && (diff == '0);
                    error_next     = 1'b0;
                    remaining_next = diff;
                    pending_next   = word.second;
                end
            end
            rne_pkg::ST_PAIR:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    symbol_next    = pending_reg;
                    last_next      = (remaining_reg == '0);
                    error_next     = 1'b0;
                    pending_next   = rne_pkg::CH_NONE;
                end
            end
            default:
            begin
                pending_next = rne_pkg::CH_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rne_pkg::ST_IDLE;
            pc_reg        <= '0;
            remaining_reg <= '0;
            pending_reg   <= rne_pkg::CH_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            remaining_reg <= remaining_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload, no reset needed
    always_ff @(posedge clk)
    begin
        symbol_reg <= symbol_next;
        last_reg   <= last_next;
        error_reg  <= error_next;
    end

    // an error transfer carries no letter and closes the run
    `RNE_ASSERT_IMP(a_error_shape, out_valid_reg && error_reg, last_reg && symbol_reg == rne_pkg::CH_NONE)
    // a normal transfer always carries a letter
    `RNE_ASSERT_IMP(a_letter_nonzero, out_valid_reg && !error_reg, symbol_reg != rne_pkg::CH_NONE)
    // the loop only runs on a nonzero, in-range remainder
    `RNE_ASSERT_IMP(a_run_remaining, state_reg == rne_pkg::ST_RUN, remaining_reg != '0 && remaining_reg <= rne_pkg::MAX_VALUE && pc_reg <= rne_pkg::LAST_STEP)
    // a pair state always holds its second letter
    `RNE_ASSERT_IMP(a_pair_pending, state_reg == rne_pkg::ST_PAIR, pending_reg != rne_pkg::CH_NONE)
    // an accepted number is range-checked next
    `RNE_ASSERT_NEXT(a_accept_check, in_xfer, state_reg == rne_pkg::ST_CHECK)

endmodule
